// ===== sv/spfa_pkg.sv =====
// spfa_pkg: shared types, codes and widths of the superpixel feature averager
// used by spfa_div and superpixel_feature_average; depends on nothing
package spfa_pkg;

  localparam int unsigned NFEAT      = 10;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned FEAT_W     = 26;
  localparam int unsigned FV_W       = 27;
  localparam int unsigned LABEL_W    = 12;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned STEP_W     = 6;

  localparam int unsigned CHANNELS_DEF = 3;
  localparam int unsigned N_LABELS_DEF = 1024;
  localparam int unsigned MAX_DIM_DEF  = 1024;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = '1;

  typedef enum logic [1:0] {
    OP_ACC    = 2'd0,
    OP_READ   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_RGB_SCALE = 3'd1,
    CFG_XY_SCALE  = 3'd2,
    CFG_CRGB      = 3'd3,
    CFG_CXY       = 3'd4,
    CFG_SKIP      = 3'd5,
    CFG_EMPTY     = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_XY     = 3'd0,
    MODE_RGB    = 3'd1,
    MODE_RGBXY  = 3'd2,
    MODE_XY_C   = 3'd3,
    MODE_ALL    = 3'd4
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_DIV  = 5'b00100,
    S_DONE = 5'b01000,
    S_CLR  = 5'b10000
  } state_e;

  // number of features a layout uses
  function automatic logic [3:0] feat_len(input logic [2:0] m, input int unsigned ch);
    logic [3:0] n;
    case (m)
      MODE_RGB:   n = 4'(ch);
      MODE_RGBXY: n = 4'(ch + 2);
      MODE_XY_C:  n = 4'(ch + 4);
      MODE_ALL:   n = 4'(2 * ch + 4);
      default:    n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/spfa_div.sv =====
// spfa_div: one lane of signed division, sum over pixel count, one bit a
// cycle while step_i is high; truncates toward zero; depends on spfa_pkg
module spfa_div (
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic                               step_i,
  input  logic signed [spfa_pkg::SUM_W-1:0]  dvd_i,
  input  logic        [spfa_pkg::CNT_W-1:0]  dvs_i,
  output logic signed [spfa_pkg::FEAT_W-1:0] quot_o
);
  import spfa_pkg::*;

  logic [SUM_W-1:0] q_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] dvs_q;
  logic             neg_q;
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [SUM_W-1:0] q_sgn;

  assign rem_sh = {rem_q, q_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign q_sgn  = neg_q ? (~q_q + SUM_W'(1)) : q_q;
  assign quot_o = q_sgn[FEAT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q   <= dvd_i[SUM_W-1] ? (~dvd_i + SUM_W'(1)) : dvd_i;
      rem_q <= '0;
      dvs_q <= dvs_i;
      neg_q <= dvd_i[SUM_W-1];
    end else if (step_i) begin
      q_q   <= {q_q[SUM_W-2:0], ge};
      rem_q <= ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
    end
  end

endmodule

// ===== sv/superpixel_feature_average.sv =====
// superpixel_feature_average: top level, feature table, pixel counts and control
// depends on spfa_pkg and spfa_div
//
// Per-superpixel mean pooling. start is taken when busy is low; every item
// gives exactly one result, shown for one cycle with result_strobe_o, and the
// receiver cannot hold it off. An accumulate first reads the label's row of
// sums and its count from the memories, then adds the scaled feature vector
// and writes back unless the label is skipped, out of range or full. A read
// or lookup that finds pixels runs ten restoring dividers side by side, one
// quotient bit a cycle; one that ends early (out of range, a skipped label on
// lookup, or empty) ends after the memory read. A clear sweeps the count
// memory one entry a cycle. After reset the same sweep runs with busy high;
// configuration writes are taken at any time through cfg_we_i.
module superpixel_feature_average #(
  parameter int unsigned CHANNELS = spfa_pkg::CHANNELS_DEF,
  parameter int unsigned N_LABELS = spfa_pkg::N_LABELS_DEF,
  parameter int unsigned MAX_DIM  = spfa_pkg::MAX_DIM_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [spfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [spfa_pkg::FEAT_W-1:0]    cfg_data_i,
  input  logic                                  start,
  output logic                                  busy,
  input  logic        [1:0]                     operation_i,
  input  logic signed [spfa_pkg::LABEL_W-1:0]   label_i,
  input  logic        [7:0]                     chan0_i,
  input  logic        [7:0]                     chan1_i,
  input  logic        [7:0]                     chan2_i,
  input  logic        [9:0]                     pos_x_i,
  input  logic        [9:0]                     pos_y_i,
  output logic                                  result_strobe_o,
  output logic        [1:0]                     status_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat0_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat1_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat2_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat3_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat4_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat5_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat6_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat7_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat8_o,
  output logic signed [spfa_pkg::FEAT_W-1:0]    feat9_o
);
  import spfa_pkg::*;

  localparam int unsigned AW = (N_LABELS > 1) ? $clog2(N_LABELS) : 1;
  localparam logic [AW-1:0]      LAST_ENTRY = AW'(N_LABELS - 1);
  localparam logic [LABEL_W:0]   LABEL_LIM  = (LABEL_W + 1)'(N_LABELS);
  localparam logic [9:0]         POS_MAX    = 10'(MAX_DIM - 1);

  // configuration registers
  logic        [2:0]         mode_q;
  logic signed [SCALE_W-1:0] rs_q, xs_q, crs_q, cxs_q;
  logic        [LABEL_W-1:0] skip_q;
  logic signed [FEAT_W-1:0]  empty_q;

  // control
  state_e               state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 pend_q, pend_d;
  logic                 strobe_q, strobe_d;
  status_e              status_q, status_d;
  logic signed [FEAT_W-1:0] fout_q [NFEAT];
  logic signed [FEAT_W-1:0] fout_d [NFEAT];

  // item held while it is worked on
  op_e                  op_q;
  logic [LABEL_W-1:0]   lab_q;
  logic signed [FV_W-1:0] fv_q [NFEAT];
  logic signed [FV_W-1:0] fv_d [NFEAT];

  // memories
  logic [NFEAT-1:0][SUM_W-1:0] sums_mem [N_LABELS];
  logic [CNT_W-1:0]            cnt_mem  [N_LABELS];
  logic [NFEAT-1:0][SUM_W-1:0] sums_rd_q, sums_wd;
  logic [CNT_W-1:0]            cnt_rd_q, cnt_wd;
  logic                        sums_we, cnt_we;
  logic [AW-1:0]               cnt_wa;

  logic                     accept;
  logic [2:0]               eff_mode;
  logic [3:0]               n_feat;
  logic                     lane_load, lane_step;
  logic signed [FEAT_W-1:0] quot [NFEAT];
  logic                     in_range, skip_hit;

  assign accept   = start && !busy;
  assign busy     = state_q != S_IDLE;
  assign eff_mode = (mode_q > MODE_ALL) ? MODE_XY : mode_q;
  assign n_feat   = feat_len(eff_mode, CHANNELS);
  assign in_range = !lab_q[LABEL_W-1] && ({1'b0, lab_q} < LABEL_LIM);
  assign skip_hit = lab_q == skip_q;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_XY;
      rs_q    <= 16'sd4096;
      xs_q    <= 16'sd4096;
      crs_q   <= 16'sd4096;
      cxs_q   <= 16'sd4096;
      skip_q  <= '1;
      empty_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:      mode_q  <= cfg_data_i[2:0];
        CFG_RGB_SCALE: rs_q    <= cfg_data_i[SCALE_W-1:0];
        CFG_XY_SCALE:  xs_q    <= cfg_data_i[SCALE_W-1:0];
        CFG_CRGB:      crs_q   <= cfg_data_i[SCALE_W-1:0];
        CFG_CXY:       cxs_q   <= cfg_data_i[SCALE_W-1:0];
        CFG_SKIP:      skip_q  <= cfg_data_i[LABEL_W-1:0];
        CFG_EMPTY:     empty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // feature vector of the incoming pixel, products registered at the transfer
  always_comb begin
    logic [7:0]  ch [3];
    logic [9:0]  px, py;
    logic signed [FV_W-1:0] prs [3];
    logic signed [FV_W-1:0] pcrs [3];
    logic signed [FV_W-1:0] pxy, pxx, pcy, pcx;
    logic [3:0] n;
    ch[0] = chan0_i;
    ch[1] = chan1_i;
    ch[2] = chan2_i;
    px = (pos_x_i > POS_MAX) ? POS_MAX : pos_x_i;
    py = (pos_y_i > POS_MAX) ? POS_MAX : pos_y_i;
    for (int c = 0; c < 3; c++) begin
      prs[c]  = FV_W'(rs_q * $signed({1'b0, ch[c]}));
      pcrs[c] = FV_W'(crs_q * $signed({1'b0, ch[c]}));
    end
    pxy = FV_W'(xs_q * $signed({1'b0, py}));
    pxx = FV_W'(xs_q * $signed({1'b0, px}));
    pcy = FV_W'(cxs_q * $signed({1'b0, py}));
    pcx = FV_W'(cxs_q * $signed({1'b0, px}));
    for (int k = 0; k < NFEAT; k++) fv_d[k] = '0;
    n = '0;
    if (eff_mode == MODE_RGB || eff_mode == MODE_ALL) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fv_d[n] = prs[c];
        n = n + 4'd1;
      end
    end
    if (eff_mode == MODE_XY || eff_mode == MODE_XY_C || eff_mode == MODE_ALL) begin
      fv_d[n] = pxy;
      fv_d[n + 4'd1] = pxx;
      n = n + 4'd2;
    end
    if (eff_mode >= MODE_RGBXY) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fv_d[n] = pcrs[c];
        n = n + 4'd1;
      end
      fv_d[n] = pcy;
      fv_d[n + 4'd1] = pcx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      lab_q <= label_i;
      for (int k = 0; k < NFEAT; k++) fv_q[k] <= fv_d[k];
    end
  end

  // new row: a first pixel after the count was zero overwrites the sums
  always_comb begin
    for (int k = 0; k < NFEAT; k++) begin
      sums_wd[k] = (cnt_rd_q == '0) ? SUM_W'(fv_q[k])
                                    : sums_rd_q[k] + SUM_W'(fv_q[k]);
    end
  end

  // sums memory, one row of ten per label
  always_ff @(posedge clk_i) begin
    if (sums_we) sums_mem[lab_q[AW-1:0]] <= sums_wd;
    if (accept)  sums_rd_q <= sums_mem[label_i[AW-1:0]];
  end

  // count memory, also swept by clear and after reset
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (accept) cnt_rd_q <= cnt_mem[label_i[AW-1:0]];
  end

  // one divider lane per feature slot
  for (genvar g = 0; g < NFEAT; g++) begin : g_lane
    spfa_div u_div (
      .clk_i  (clk_i),
      .load_i (lane_load),
      .step_i (lane_step),
      .dvd_i  (sums_rd_q[g]),
      .dvs_i  (cnt_rd_q),
      .quot_o (quot[g])
    );
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    clr_d     = clr_q;
    pend_d    = pend_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    for (int k = 0; k < NFEAT; k++) fout_d[k] = fout_q[k];
    sums_we   = 1'b0;
    cnt_we    = 1'b0;
    cnt_wa    = lab_q[AW-1:0];
    cnt_wd    = cnt_rd_q + CNT_W'(1);
    lane_load = 1'b0;
    lane_step = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(operation_i) == OP_CLEAR) begin
            state_d = S_CLR;
            clr_d   = '0;
            pend_d  = 1'b1;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_IDLE;
        for (int k = 0; k < NFEAT; k++) fout_d[k] = '0;
        if (op_q == OP_ACC) begin
          strobe_d = 1'b1;
          if (skip_hit) begin
            status_d = ST_EMPTY;
          end else if (!in_range) begin
            status_d = ST_RANGE;
          end else if (cnt_rd_q == CNT_FULL) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_OK;
            sums_we  = 1'b1;
            cnt_we   = 1'b1;
          end
        end else if ((op_q == OP_LOOKUP && skip_hit) || (in_range && cnt_rd_q == '0)) begin
          // skipped label on lookup, or an entry with no pixels
          strobe_d = 1'b1;
          status_d = ST_EMPTY;
          for (int k = 0; k < NFEAT; k++) begin
            if (4'(k) < n_feat) fout_d[k] = empty_q;
          end
        end else if (!in_range) begin
          strobe_d = 1'b1;
          status_d = ST_RANGE;
        end else begin
          lane_load = 1'b1;
          step_d    = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        lane_step = 1'b1;
        if (step_q == STEP_LAST) state_d = S_DONE;
        else step_d = step_q + STEP_W'(1);
      end
      S_DONE: begin
        strobe_d = 1'b1;
        status_d = ST_OK;
        state_d  = S_IDLE;
        for (int k = 0; k < NFEAT; k++) begin
          fout_d[k] = (4'(k) < n_feat) ? quot[k] : '0;
        end
      end
      S_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_q;
        cnt_wd = '0;
        if (clr_q == LAST_ENTRY) begin
          state_d = S_IDLE;
          if (pend_q) begin
            pend_d   = 1'b0;
            strobe_d = 1'b1;
            status_d = ST_OK;
            for (int k = 0; k < NFEAT; k++) fout_d[k] = '0;
          end
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset starts with a sweep of the counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      step_q   <= '0;
      clr_q    <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NFEAT; k++) fout_q[k] <= fout_d[k];
  end

  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign feat0_o = fout_q[0];
  assign feat1_o = fout_q[1];
  assign feat2_o = fout_q[2];
  assign feat3_o = fout_q[3];
  assign feat4_o = fout_q[4];
  assign feat5_o = fout_q[5];
  assign feat6_o = fout_q[6];
  assign feat7_o = fout_q[7];
  assign feat8_o = fout_q[8];
  assign feat9_o = fout_q[9];

  // results never come in consecutive cycles
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("back to back results");

  // no memory write while the dividers run
  a_div_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (!sums_we && !cnt_we))
    else $error("memory write during divide");

  // a clear transfer starts the sweep
  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_CLEAR) |=> (state_q == S_CLR && pend_q))
    else $error("clear did not start sweep");

  // out of range results carry no features
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && status_o == ST_RANGE) |-> (feat0_o == '0 && feat9_o == '0))
    else $error("features on out of range result");

endmodule
